/* sv/chht_pkg.sv */
package chht_pkg;

  // Default sizes of the table
  localparam int MAX_BUCKETS_DEF = 64;
  localparam int CHAIN_DEPTH_DEF = 4;
  localparam int QUEUE_DEPTH     = 2;

  // Field widths
  localparam int LETTER_W     = 5;
  localparam int DIGIT_W      = 4;
  localparam int KEY_W        = 2 * LETTER_W + DIGIT_W;
  localparam int NUM_W        = 32;
  localparam int DESC_W       = 64;
  localparam int SIZE_W       = 7;
  localparam int HASH_W       = 14;
  localparam int STATUS_W     = 3;
  localparam int BUCKET_OUT_W = 6;
  localparam int APB_ADDR_W   = 2;
  localparam int APB_DATA_W   = 32;

  // Remainder unit retires two dividend bits per cycle
  localparam int HASH_STEPS = HASH_W / 2;
  localparam int STEP_W     = $clog2(HASH_STEPS);

  // Key alphabet: the first letter weighs 26 * 10, the second letter 10
  localparam int LETTER_SPAN = 26;
  localparam int DIGIT_SPAN  = 10;

  localparam logic [SIZE_W-1:0]     TABLE_SIZE_RESET = 7'd31;
  localparam logic [APB_ADDR_W-1:0] ADDR_TABLE_SIZE  = 2'd0;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_MISSING   = 3'd4
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic signed [NUM_W-1:0]  number;
    logic [DESC_W-1:0]        desc;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t entry;
  } req_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int REQ_W   = $bits(req_t);

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

  // 260*first + 10*second + digit, on the raw key bits
  function automatic logic [HASH_W-1:0] hash_of(logic [KEY_W-1:0] key);
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
    logic [HASH_W-1:0] d;
    a = HASH_W'(key[KEY_W-1 -: LETTER_W]);
    b = HASH_W'(key[DIGIT_W +: LETTER_W]);
    d = HASH_W'(key[DIGIT_W-1:0]);
    return a * HASH_W'(LETTER_SPAN * DIGIT_SPAN) + b * HASH_W'(DIGIT_SPAN) + d;
  endfunction

  // One restoring step: shift in a dividend bit, subtract the divisor once if it fits
  function automatic logic [SIZE_W-1:0] mod_step(logic [SIZE_W-1:0] rem,
                                                 logic bit_in,
                                                 logic [SIZE_W-1:0] divisor);
    logic [SIZE_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, divisor}) begin
      t = t - {1'b0, divisor};
    end
    return t[SIZE_W-1:0];
  endfunction

endpackage

/* sv/chained_hash_table_insert_search_top.sv */
// Throughput: the remainder unit retires two hash bits per cycle; the front
//   end takes a new request once it has pushed the last one to the queue,
//   even while the back end still scans the slots for an earlier one.
// Reset (rst, synchronous): table_size returns to 31 and every slot is marked
//   empty at once; the slot store itself keeps old contents.
// The receiver cannot stall: done is high for one cycle per request.
module chained_hash_table_insert_search_top import chht_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // Request transfer
  input  logic                    start,
  output logic                    busy,
  input  logic                    op,
  input  logic [LETTER_W-1:0]     key_first_letter,
  input  logic [LETTER_W-1:0]     key_second_letter,
  input  logic [DIGIT_W-1:0]      key_digit,
  input  logic signed [NUM_W-1:0] item_number,
  input  logic [DESC_W-1:0]       item_desc,
  // Result transfer
  output logic                    done,
  output logic [STATUS_W-1:0]     status,
  output logic [BUCKET_OUT_W-1:0] bucket,
  output logic signed [NUM_W-1:0] found_number,
  output logic [DESC_W-1:0]       found_desc,
  // Configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int QW = REQ_W + BW;

  logic [SIZE_W-1:0] table_size;
  req_t              req_in;
  req_t              fe_req;
  logic [BW-1:0]     fe_bucket;
  logic              q_push;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [QW-1:0]     q_head;
  req_t              bk_req;
  logic [BW-1:0]     bk_in_bucket;
  logic [BW-1:0]     bk_bucket;
  status_t           bk_status;

  // Register file: one size register; writes complete on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TABLE_SIZE) ? APB_DATA_W'(table_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TABLE_SIZE) begin
      table_size <= pwdata[SIZE_W-1:0];
    end
  end

  // Pack the request; the key keeps all raw symbol bits
  assign req_in.op           = op_t'(op);
  assign req_in.entry.key    = {key_first_letter, key_second_letter, key_digit};
  assign req_in.entry.number = item_number;
  assign req_in.entry.desc   = item_desc;

  // Front: hash and reduce modulo the bucket count
  chht_front #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_in      (req_in),
    .table_size  (table_size),
    .full        (q_full),
    .busy        (busy),
    .push        (q_push),
    .push_req    (fe_req),
    .push_bucket (fe_bucket)
  );

  // Hold classified requests until the back end frees up
  chht_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({fe_req, fe_bucket}),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign bk_req       = req_t'(q_head[QW-1:BW]);
  assign bk_in_bucket = q_head[BW-1:0];

  // Back: walk the bucket chain, then insert or report
  chht_back #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .head_req     (bk_req),
    .head_bucket  (bk_in_bucket),
    .pop          (q_pop),
    .done         (done),
    .status       (bk_status),
    .bucket       (bk_bucket),
    .found_number (found_number),
    .found_desc   (found_desc)
  );

  assign status = bk_status;
  assign bucket = BUCKET_OUT_W'(bk_bucket);

  a_start_holds_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("front end took a request but did not go busy");

endmodule

/* sv/chht_ram.sv */
module chht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/chht_queue.sv */
module chht_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

/* sv/chht_front.sv */
module chht_front import chht_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              req_in,
  input  logic [SIZE_W-1:0] table_size,
  input  logic              full,
  output logic              busy,
  output logic              push,
  output req_t              push_req,
  output logic [BW-1:0]     push_bucket
);

  fe_state_t         state;
  fe_state_t         state_next;
  req_t              req;
  logic [HASH_W-1:0] dividend;
  logic [SIZE_W-1:0] divisor;
  logic [SIZE_W-1:0] size_used;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] rem_next;
  logic [STEP_W-1:0] step;
  logic              accept;
  logic              last_step;

  // Clamp the configured size into 1..MAX_BUCKETS
  always_comb begin
    if (table_size == '0) begin
      size_used = SIZE_W'(1);
    end else if (int'(table_size) > MAX_BUCKETS) begin
      size_used = SIZE_W'(MAX_BUCKETS);
    end else begin
      size_used = table_size;
    end
  end

  assign rem_next  = mod_step(mod_step(rem, dividend[HASH_W-1], divisor),
                              dividend[HASH_W-2], divisor);
  assign last_step = (step == STEP_W'(HASH_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      FE_IDLE: begin
        if (start) begin
          state_next = FE_DIV;
        end
      end
      FE_DIV: begin
        if (last_step) begin
          state_next = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!full) begin
          state_next = FE_IDLE;
        end
      end
      default: state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    accept = 1'b0;
    push   = 1'b0;
    case (state)
      FE_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      FE_DIV:  push = 1'b0;
      FE_PUSH: push = !full;
      default: busy = 1'b1;
    endcase
  end

  assign push_req    = req;
  assign push_bucket = BW'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= req_in;
      dividend <= hash_of(req_in.entry.key);
      divisor  <= size_used;
      rem      <= '0;
      step     <= '0;
    end else if (state == FE_DIV) begin
      dividend <= dividend << 2;
      rem      <= rem_next;
      step     <= step + STEP_W'(1);
    end
  end

endmodule

/* sv/chht_back.sv */
module chht_back import chht_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF,
  localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
  localparam int SLOTS = MAX_BUCKETS * CHAIN_DEPTH,
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int IW    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    empty,
  input  req_t                    head_req,
  input  logic [BW-1:0]           head_bucket,
  output logic                    pop,
  output logic                    done,
  output status_t                 status,
  output logic [BW-1:0]           bucket,
  output logic signed [NUM_W-1:0] found_number,
  output logic [DESC_W-1:0]       found_desc
);

  bk_state_t         state;
  bk_state_t         state_next;
  req_t              cur;
  logic [BW-1:0]     cur_bucket;
  logic [AW-1:0]     base;
  logic [IW:0]       idx;
  logic              chk_vld;
  logic [IW-1:0]     chk_idx;
  logic [AW-1:0]     chk_addr;
  logic              hit;
  entry_t            hit_entry;
  logic              free;
  logic [IW-1:0]     free_idx;
  logic [SLOTS-1:0]  slot_valid;
  logic              issue;
  logic              finish;
  logic              ins_ok;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [ENTRY_W-1:0] rd_data;
  entry_t            rd_entry;
  status_t           status_next;

  assign base     = AW'(cur_bucket * CHAIN_DEPTH);
  assign rd_addr  = base + AW'(idx[IW-1:0]);
  assign chk_addr = base + AW'(chk_idx);
  assign wr_addr  = base + AW'(free_idx);
  assign rd_entry = entry_t'(rd_data);

  chht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ins_ok),
    .waddr (wr_addr),
    .wdata (cur.entry),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (chk_vld && chk_idx == IW'(CHAIN_DEPTH - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    case (state)
      BK_IDLE: pop    = !empty;
      BK_SCAN: issue  = (idx < (IW + 1)'(CHAIN_DEPTH));
      BK_DONE: finish = 1'b1;
      default: finish = 1'b0;
    endcase
  end

  assign ins_ok = finish && (cur.op == OP_INSERT) && !hit && free;

  always_comb begin
    if (cur.op == OP_INSERT) begin
      if (hit) begin
        status_next = ST_DUPLICATE;
      end else if (!free) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
      end
    end else begin
      status_next = hit ? ST_FOUND : ST_MISSING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      done       <= 1'b0;
      chk_vld    <= 1'b0;
      slot_valid <= '0;
    end else begin
      state   <= state_next;
      done    <= finish;
      chk_vld <= issue;
      if (ins_ok) begin
        slot_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur        <= head_req;
      cur_bucket <= head_bucket;
      idx        <= '0;
      hit        <= 1'b0;
      free       <= 1'b0;
    end else begin
      if (issue) begin
        idx <= idx + (IW + 1)'(1);
      end
      // First matching slot wins; lowest empty slot takes an insert
      if (chk_vld) begin
        if (slot_valid[chk_addr]) begin
          if (!hit && rd_entry.key == cur.entry.key) begin
            hit       <= 1'b1;
            hit_entry <= rd_entry;
          end
        end else if (!free) begin
          free     <= 1'b1;
          free_idx <= chk_idx;
        end
      end
    end
    chk_idx <= idx[IW-1:0];
    if (finish) begin
      status <= status_next;
      bucket <= cur_bucket;
      if (cur.op == OP_SEARCH && hit) begin
        found_number <= hit_entry.number;
        found_desc   <= hit_entry.desc;
      end else begin
        found_number <= '0;
        found_desc   <= '0;
      end
    end
  end

  a_scan_complete: assert property (@(posedge clk) disable iff (rst)
    finish |-> idx == (IW + 1)'(CHAIN_DEPTH))
    else $error("request finished before every chain slot was checked");

  a_insert_marks_valid: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> slot_valid[$past(wr_addr)])
    else $error("stored entry not marked valid");

endmodule
